@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker in ust_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define UST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define UST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ust_pkg.sv @@
package ust_pkg;

    // request modes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ELSEWHERE = 3'd1;
    localparam logic [2:0] ST_BADINDEX  = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_NOTFOUND  = 3'd6;

    // marker held by an empty slot
    localparam logic [31:0] EMPTY_MARK = 32'hFFFF_FF9D;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic put;
    } t_ust_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_ust_sts;

endpackage

@@ rtl/core/ust_ram.sv @@
module ust_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/ust_datapath.sv @@
module ust_datapath #(
    parameter int SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ust_pkg::t_ust_cmd i_cmd,
    output ust_pkg::t_ust_sts o_sts,
    input  logic [1:0]        i_mode,
    input  logic [3:0]        i_slot_index,
    input  logic signed [31:0] i_item_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_status,
    output logic [2:0]        o_result_slot
);

    import ust_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = (AW > 4) ? AW : 4;

    // request registers
    logic [1:0]    r_mode;
    logic [3:0]    r_idx;
    logic [31:0]   r_val;
    logic          r_bad;

    // scan pipeline
    logic [AW-1:0] r_addr;
    logic          r_chk_vld;
    logic [AW-1:0] r_chk_addr;
    logic [31:0]   w_rdata;
    logic [31:0]   w_eff;
    logic          w_hit;
    logic          w_is_empty;
    logic          w_idx_match;

    // scan results
    logic          r_hit_any;
    logic [AW-1:0] r_hit_idx;
    logic          r_emp_any;
    logic [AW-1:0] r_emp_idx;
    logic          r_req_empty;

    // slot occupancy, cleared by reset
    logic [SLOTS-1:0] r_valid;

    // decision
    logic [2:0]    n_status;
    logic [AW-1:0] n_tgt;
    logic          w_ins_we;
    logic          w_del_we;
    logic [AW-1:0] w_req_addr;

    // output register
    logic          r_out_valid;

    assign w_req_addr = AW'(r_idx);

    ust_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ins_we),
        .i_waddr (n_tgt),
        .i_wdata (r_val),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // compare of the entry read last cycle
    assign w_eff       = r_valid[r_chk_addr] ? w_rdata : EMPTY_MARK;
    assign w_hit       = (w_eff == r_val);
    assign w_is_empty  = (w_eff == EMPTY_MARK);
    assign w_idx_match = (CW'(r_chk_addr) == CW'(r_idx));

    // outcome of the request from the scan flags
    always_comb begin
        n_status = ST_BADINDEX;
        n_tgt    = '0;
        w_ins_we = 1'b0;
        w_del_we = 1'b0;
        unique case (r_mode)
            MODE_INSERT: begin
                if (r_bad) begin
                    n_status = ST_BADINDEX;
                end else if (r_hit_any) begin
                    n_status = ST_DUPLICATE;
                end else if (r_req_empty) begin
                    n_status = ST_OK;
                    n_tgt    = w_req_addr;
                    w_ins_we = i_cmd.decide;
                end else if (r_emp_any) begin
                    n_status = ST_ELSEWHERE;
                    n_tgt    = r_emp_idx;
                    w_ins_we = i_cmd.decide;
                end else begin
                    n_status = ST_FULL;
                end
            end
            MODE_DELETE: begin
                if (r_bad) begin
                    n_status = ST_BADINDEX;
                end else if (!r_req_empty) begin
                    n_status = ST_OK;
                    n_tgt    = w_req_addr;
                    w_del_we = i_cmd.decide;
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            MODE_SEARCH: begin
                if (r_hit_any) begin
                    n_status = ST_OK;
                    n_tgt    = r_hit_idx;
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            default: begin
                n_status = ST_BADINDEX;
            end
        endcase
    end

    // request capture and scan flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode      <= i_mode;
            r_idx       <= i_slot_index;
            r_val       <= i_item_value;
            r_bad       <= (32'(i_slot_index) >= 32'(SLOTS));
            r_hit_any   <= 1'b0;
            r_hit_idx   <= '0;
            r_emp_any   <= 1'b0;
            r_emp_idx   <= '0;
            r_req_empty <= 1'b0;
        end else if (r_chk_vld) begin
            if (w_hit && !r_hit_any) begin
                r_hit_any <= 1'b1;
                r_hit_idx <= r_chk_addr;
            end
            if (w_is_empty && !r_emp_any) begin
                r_emp_any <= 1'b1;
                r_emp_idx <= r_chk_addr;
            end
            if (w_idx_match) begin
                r_req_empty <= w_is_empty;
            end
        end
        r_chk_addr <= r_addr;
    end

    // held result between decide and output transfer
    logic [2:0] r_res_status;
    logic [2:0] r_res_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_res_status <= n_status;
            r_res_slot   <= (n_status == ST_OK || n_status == ST_ELSEWHERE) ? 3'(n_tgt) : 3'd0;
        end
    end

    // control state: scan address, occupancy, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_chk_vld   <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_addr <= '0;
            end else if (i_cmd.scan) begin
                r_addr <= r_addr + AW'(1);
            end
            r_chk_vld <= i_cmd.scan;
            if (w_ins_we) begin
                r_valid[n_tgt] <= 1'b1;
            end else if (w_del_we) begin
                r_valid[n_tgt] <= 1'b0;
            end
            if (i_cmd.put) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    logic [2:0] r_o_status;
    logic [2:0] r_o_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_o_status <= r_res_status;
            r_o_slot   <= r_res_slot;
        end
    end

    assign o_sts.scan_last = (r_addr == AW'(SLOTS - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_result_slot   = r_o_slot;

endmodule

@@ rtl/core/ust_ctrl.sv @@
module ust_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ust_pkg::t_ust_sts i_sts,
    output ust_pkg::t_ust_cmd o_cmd
);

    import ust_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_PUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_PUT;
            end
            S_PUT: begin
                o_cmd.put = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

@@ rtl/core/unique_value_slot_table.sv @@
// Slot table of SLOTS signed 32-bit entries with a duplicate check.
// Input channel (i_in_valid / o_in_ready): one request per transfer with
// i_mode (insert, delete by slot, search by value), i_slot_index and
// i_item_value. Output channel (o_out_valid / i_out_ready): one result per
// request, o_status and o_result_slot, in request order.
// Each request runs a scan that reads every slot through the single read
// port of the slot memory and checks each entry with one shared set of
// compares. One request is in work at a time; the next one is taken only
// after the current result has moved to the output register.
// The finished result sits in an output register; a new request is taken
// while that result still waits. When the receiver stalls, the following
// request finishes its scan and then waits for the output register.
// Reset (synchronous, active low) empties every slot through per-slot
// occupancy bits and drops any pending result.
module unique_value_slot_table #(
    parameter int SLOTS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [3:0]         i_slot_index,
    input  logic signed [31:0] i_item_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic [2:0]         o_result_slot
);

    import ust_pkg::*;

    t_ust_cmd w_cmd;
    t_ust_sts w_sts;

    ust_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ust_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_mode        (i_mode),
        .i_slot_index  (i_slot_index),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_result_slot (o_result_slot)
    );

endmodule

@@ rtl/core/ust_checker.sv @@
`include "assert_macros.svh"

module ust_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [2:0]         o_status,
    input logic [2:0]         o_result_slot
);

    import ust_pkg::*;

    // a failed request never reports a slot
    `UST_ASSERT_NOW(a_fail_slot_zero, i_clk, i_rst_n, o_out_valid && (o_status == ST_BADINDEX || o_status == ST_DUPLICATE || o_status == ST_FULL || o_status == ST_EMPTY || o_status == ST_NOTFOUND), o_result_slot == 3'd0, "failed request reports a nonzero slot")

    // only defined status codes reach the port
    `UST_ASSERT_NOW(a_status_code, i_clk, i_rst_n, o_out_valid, o_status != 3'd7, "undefined status code")

    // one request in work: an input transfer drops ready for the next cycle
    `UST_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready stays high after an input transfer")

    // a stalled result stays and keeps its payload
    `UST_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_status) && $stable(o_result_slot), "stalled result changed")

endmodule

bind unique_value_slot_table ust_checker u_ust_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_result_slot (o_result_slot)
);
